/* rtl/remote_button_event_detector_top_assert.svh */
// Assertion macros shared by the detector RTL.
`ifndef REMOTE_BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH
`define REMOTE_BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define RBED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RBED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define RBED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/rbed_pkg.sv */
`timescale 1ns / 1ps
package rbed_pkg;

  localparam int unsigned MAX_EV     = 3;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CAND_NUM   = 7;

  localparam logic [4:0] EV_PRESS      = 5'd0;
  localparam logic [4:0] EV_RELEASE    = 5'd1;
  localparam logic [4:0] EV_CHANGE     = 5'd2;
  localparam logic [4:0] EV_HOLD       = 5'd3;
  localparam logic [4:0] EV_CLICK_BASE = 5'd4;
  localparam logic [4:0] EV_CRAZY      = 5'd14;
  localparam logic [4:0] EV_LONG_BASE  = 5'd15;

  localparam logic [7:0] CLICK_LIMIT = 8'd10;
  localparam logic [7:0] CNT_MAX     = 8'd255;

  localparam logic [2:0] REG_CODE_ON   = 3'd0;
  localparam logic [2:0] REG_CODE_OFF  = 3'd1;
  localparam logic [2:0] REG_MODE      = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd3;
  localparam logic [2:0] REG_NOISE     = 3'd4;
  localparam logic [2:0] REG_HOLD_TIME = 3'd5;
  localparam logic [2:0] REG_HOLD_REP  = 3'd6;
  localparam logic [2:0] REG_GAP       = 3'd7;

  typedef struct packed {
    logic [4:0] kind;
    logic       level;
    logic       last;
  } ev_entry_t;

endpackage

/* rtl/remote_button_event_detector_top.sv */
`timescale 1ns / 1ps
// Remote button event detector.
// The input stream carries one millisecond tick per transaction: in_tuser is the
// code-valid flag and in_tdata the received remote code. Every accepted tick
// advances the internal time, updates the raw, filtered and stable levels and the
// click and hold counters, and yields zero to three events.
// Each event leaves on the output stream as one transaction: out_tuser is the
// event kind, out_tdata bit 0 the stable level after the tick, and out_tlast marks
// the final event of a tick. Ticks that yield no event produce no transaction.
// A tick is processed in the cycle it is accepted, and its events are written into
// the event queue at that edge. One tick is accepted every cycle while the
// eight-entry event queue has room for three more events; the queue drains one
// event per cycle while out_tready is high, so a long run of multi-event ticks is
// paced by the output port. When the receiver stalls, events wait in the queue and
// in_tready falls once fewer than three entries are free.
// Reset clears the time, all levels, stamps, counters, the queue and all
// configuration registers. The user must write registers through the APB port only
// while no tick is in flight; the block itself does not enforce this.
module remote_button_event_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] rx_code
  input  logic        in_tuser,   // [0] code_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] stable_level, [7:1] zero
  output logic [4:0]  out_tuser,  // [4:0] event_kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rbed_pkg::*;

  `include "remote_button_event_detector_top_assert.svh"

  logic [31:0] code_on_r, code_off_r;
  logic [1:0]  mode_r;
  logic [15:0] deb_dly_r, nf_dly_r, hold_time_r, hold_rep_r, gap_r;

  logic [31:0] tick_r, mono_st_r, deb_st_r, filt_st_r, chg_st_r;
  logic        raw_r, stable_r, cand_r;
  logic [7:0]  clicks_r, holds_r;

  logic [31:0] mono_st_nxt, deb_st_nxt, filt_st_nxt, chg_st_nxt;
  logic        raw_nxt, stable_nxt, cand_nxt;
  logic [7:0]  clicks_nxt, holds_nxt;

  ev_entry_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;

  logic        acc, pop, cfg_wr;
  logic        mono, bist;
  logic [31:0] now, delta;
  logic        match_on, match_off;
  logic        deb_open;
  logic        edge_up, edge_dn;
  logic [24:0] hold_limit;
  logic [23:0] hold_prod;

  logic [CAND_NUM-1:0] cand_v;
  logic [4:0]          cand_k [CAND_NUM];
  logic [4:0]          ev_kind [MAX_EV];
  logic [1:0]          ev_cnt;

  assign acc    = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mono   = mode_r[0];
  assign bist   = mode_r[1];
  assign now    = tick_r + 32'd1;
  assign delta  = now - chg_st_r;

  assign match_on  = in_tuser && (in_tdata == code_on_r);
  assign match_off = in_tuser && !match_on && (in_tdata == code_off_r);

  assign hold_prod  = 24'(holds_r) * 24'(hold_rep_r);
  assign hold_limit = {9'd0, hold_time_r} + {1'b0, hold_prod};

  always_comb begin
    mono_st_nxt = mono_st_r;
    raw_nxt     = raw_r;
    if (match_on) begin
      raw_nxt = 1'b1;
    end else if (match_off) begin
      raw_nxt = 1'b0;
    end
    if (mono && (match_on || match_off)) begin
      mono_st_nxt = now;
    end
    // A fresh match restarts the stamp at now, so the fallback cannot fire then.
    if (mono && !(match_on || match_off) && ((now - mono_st_r) > {16'd0, deb_dly_r})) begin
      raw_nxt = (code_on_r == 32'd0);
    end

    deb_open    = (deb_dly_r == 16'd0) || ((now - deb_st_r) > {16'd0, deb_dly_r});
    cand_nxt    = cand_r;
    filt_st_nxt = filt_st_r;
    deb_st_nxt  = deb_st_r;
    stable_nxt  = stable_r;
    edge_up     = 1'b0;
    edge_dn     = 1'b0;
    if (deb_open) begin
      if (raw_nxt != stable_r) begin
        if ((nf_dly_r != 16'd0) && (raw_nxt != cand_r)) begin
          cand_nxt    = raw_nxt;
          filt_st_nxt = now;
        end else if ((now - filt_st_r) > {16'd0, nf_dly_r}) begin
          deb_st_nxt = now;
          stable_nxt = raw_nxt;
          edge_up    = raw_nxt;
          edge_dn    = !raw_nxt;
        end
      end else begin
        cand_nxt = stable_r;
      end
    end
  end

  always_comb begin
    cand_v     = '0;
    cand_k[0]  = match_on ? EV_PRESS : EV_RELEASE;
    cand_k[1]  = edge_up ? EV_PRESS : EV_RELEASE;
    cand_k[2]  = EV_CHANGE;
    cand_k[3]  = EV_HOLD;
    cand_k[4]  = clicks_r[4:0] + (EV_CLICK_BASE - 5'd1);
    cand_k[5]  = EV_CRAZY;
    cand_k[6]  = clicks_r[4:0] + (EV_LONG_BASE - 5'd1);
    chg_st_nxt = chg_st_r;
    clicks_nxt = clicks_r;
    holds_nxt  = holds_r;

    cand_v[0] = !mono && (match_on || match_off);
    if (edge_up || edge_dn) begin
      cand_v[1]  = 1'b1;
      cand_v[2]  = 1'b1;
      chg_st_nxt = now;
      if ((edge_up || bist) && (clicks_r != CNT_MAX)) begin
        clicks_nxt = clicks_r + 8'd1;
      end
    end else if (!bist && stable_nxt) begin
      if ((clicks_r <= 8'd1) && (hold_time_r != 16'd0) &&
          (delta > {7'd0, hold_limit}) &&
          ((hold_rep_r != 16'd0) || (holds_r == 8'd0))) begin
        cand_v[3] = 1'b1;
        if (holds_r != CNT_MAX) begin
          holds_nxt = holds_r + 8'd1;
        end
      end
    end else begin
      if (gap_r == 16'd0) begin
        holds_nxt  = 8'd0;
        clicks_nxt = 8'd0;
      end else if (delta > {16'd0, gap_r}) begin
        if (holds_r == 8'd0) begin
          cand_v[4] = (clicks_r >= 8'd1) && (clicks_r <= CLICK_LIMIT);
          cand_v[5] = (clicks_r >= CLICK_LIMIT);
        end else begin
          cand_v[6] = (clicks_r >= 8'd1) && (clicks_r <= CLICK_LIMIT + 8'd1);
        end
        holds_nxt  = 8'd0;
        clicks_nxt = 8'd0;
      end
    end
  end

  always_comb begin
    ev_cnt = 2'd0;
    for (int j = 0; j < MAX_EV; j++) begin
      ev_kind[j] = EV_PRESS;
    end
    for (int j = 0; j < CAND_NUM; j++) begin
      if (cand_v[j] && (ev_cnt != 2'd3)) begin
        ev_kind[ev_cnt] = cand_k[j];
        ev_cnt          = ev_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
      cand_r    <= 1'b0;
      mono_st_r <= '0;
      deb_st_r  <= '0;
      filt_st_r <= '0;
      chg_st_r  <= '0;
      clicks_r  <= '0;
      holds_r   <= '0;
    end else if (acc) begin
      tick_r    <= now;
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
      cand_r    <= cand_nxt;
      mono_st_r <= mono_st_nxt;
      deb_st_r  <= deb_st_nxt;
      filt_st_r <= filt_st_nxt;
      chg_st_r  <= chg_st_nxt;
      clicks_r  <= clicks_nxt;
      holds_r   <= holds_nxt;
    end
  end

  assign in_tready = (cnt_r <= FIFO_CW'(FIFO_DEPTH - MAX_EV));
  assign cnt_nxt   = cnt_r + (acc ? FIFO_CW'(ev_cnt) : '0) - (pop ? FIFO_CW'(1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(ev_cnt);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MAX_EV; i++) begin
        if (2'(i) < ev_cnt) begin
          fifo_mem[wr_ptr_r + FIFO_AW'(i)] <= '{kind:  ev_kind[i],
                                                 level: stable_nxt,
                                                 last:  (2'(i) == ev_cnt - 2'd1)};
        end
      end
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = fifo_mem[rd_ptr_r].kind;
  assign out_tdata  = {7'd0, fifo_mem[rd_ptr_r].level};
  assign out_tlast  = fifo_mem[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_on_r   <= '0;
      code_off_r  <= '0;
      mode_r      <= '0;
      deb_dly_r   <= '0;
      nf_dly_r    <= '0;
      hold_time_r <= '0;
      hold_rep_r  <= '0;
      gap_r       <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_CODE_ON:   code_on_r   <= cfg_pwdata;
        REG_CODE_OFF:  code_off_r  <= cfg_pwdata;
        REG_MODE:      mode_r      <= cfg_pwdata[1:0];
        REG_DEBOUNCE:  deb_dly_r   <= cfg_pwdata[15:0];
        REG_NOISE:     nf_dly_r    <= cfg_pwdata[15:0];
        REG_HOLD_TIME: hold_time_r <= cfg_pwdata[15:0];
        REG_HOLD_REP:  hold_rep_r  <= cfg_pwdata[15:0];
        REG_GAP:       gap_r       <= cfg_pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_CODE_ON:   cfg_prdata = code_on_r;
      REG_CODE_OFF:  cfg_prdata = code_off_r;
      REG_MODE:      cfg_prdata = {30'd0, mode_r};
      REG_DEBOUNCE:  cfg_prdata = {16'd0, deb_dly_r};
      REG_NOISE:     cfg_prdata = {16'd0, nf_dly_r};
      REG_HOLD_TIME: cfg_prdata = {16'd0, hold_time_r};
      REG_HOLD_REP:  cfg_prdata = {16'd0, hold_rep_r};
      REG_GAP:       cfg_prdata = {16'd0, gap_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  `RBED_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= FIFO_CW'(FIFO_DEPTH), "event queue overflow")
  `RBED_ASSERT_NEXT(a_ev_visible, acc && (ev_cnt != 2'd0), out_tvalid, "event not queued")
  `RBED_ASSERT_NEXT(a_level_hold, !acc, $stable(stable_r), "level moved without a tick")
  `RBED_ASSERT_NEXT(a_tick_step, acc, tick_r == $past(tick_r) + 32'd1, "time not advanced")
  `RBED_ASSERT_SAME(a_tail_last, out_tvalid && (cnt_r == FIFO_CW'(1)), out_tlast,
                    "queue tail is not the last event of its tick")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rbed_pkg::*;

  localparam logic [1:0] MODE_PLAIN = 2'b00;
  localparam logic [1:0] MODE_MONO  = 2'b01;
  localparam logic [1:0] MODE_BIST  = 2'b10;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic        valid;
    logic [31:0] code;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor copy of the register file.
  logic [31:0] cf_code_on = 32'd0;
  logic [31:0] cf_code_off = 32'd0;
  logic [1:0]  cf_mode = 2'd0;
  logic [15:0] cf_debounce = 16'd0;
  logic [15:0] cf_noise = 16'd0;
  logic [15:0] cf_hold_time = 16'd0;
  logic [15:0] cf_hold_rep = 16'd0;
  logic [15:0] cf_gap = 16'd0;

  // Predictor copy of the detector state.
  logic [31:0] ms_now = 32'd0;
  logic [31:0] mono_stamp = 32'd0;
  logic [31:0] deb_stamp = 32'd0;
  logic [31:0] filt_stamp = 32'd0;
  logic [31:0] chg_stamp = 32'd0;
  logic        raw_lv = 1'b0;
  logic        stab_lv = 1'b0;
  logic        cand_lv = 1'b0;
  logic [7:0]  clicks = 8'd0;
  logic [7:0]  holds = 8'd0;

  tick_t      tick_q[$];
  ev_entry_t  event_q[$];
  tick_t      next_tick;
  ev_entry_t  want_ev;
  int         queued_ticks = 0;
  int         mismatches = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         rx_wait = 0;
  int         quiet_cycles = 0;
  logic       idle_on = 1'b1;
  logic       rx_hold_req = 1'b0;

  remote_button_event_detector_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] rx_code
    .in_tuser   (in_tuser),    // [0] code_valid
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] stable_level, [7:1] zero
    .out_tuser  (out_tuser),   // [4:0] event_kind
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] sat_bump(input logic [7:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 8'd1;
  endfunction

  function automatic void predict_tick(input logic cv, input logic [31:0] code);
    logic [4:0]  kinds[$];
    logic [31:0] delta;
    logic [63:0] hold_lim;
    logic        mono;
    logic        bist;
    logic        moved;
    ev_entry_t   ev;
    mono = cf_mode[0];
    bist = cf_mode[1];
    moved = 1'b0;
    ms_now = ms_now + 32'd1;
    delta = ms_now - chg_stamp;
    if (cv) begin
      if (code == cf_code_on) begin
        raw_lv = 1'b1;
        if (mono) mono_stamp = ms_now;
        else kinds.push_back(EV_PRESS);
      end else if (code == cf_code_off) begin
        raw_lv = 1'b0;
        if (mono) mono_stamp = ms_now;
        else kinds.push_back(EV_RELEASE);
      end
    end
    if (mono && (ms_now - mono_stamp) > 32'(cf_debounce)) raw_lv = (cf_code_on == 32'd0);
    if (cf_debounce == 16'd0 || (ms_now - deb_stamp) > 32'(cf_debounce)) begin
      if (raw_lv != stab_lv) begin
        if (cf_noise != 16'd0 && raw_lv != cand_lv) begin
          cand_lv = raw_lv;
          filt_stamp = ms_now;
        end else if ((ms_now - filt_stamp) > 32'(cf_noise)) begin
          deb_stamp = ms_now;
          stab_lv = raw_lv;
          moved = 1'b1;
        end
      end else begin
        cand_lv = stab_lv;
      end
    end
    if (moved) begin
      kinds.push_back(stab_lv ? EV_PRESS : EV_RELEASE);
      kinds.push_back(EV_CHANGE);
      chg_stamp = ms_now;
      if (stab_lv || bist) clicks = sat_bump(clicks);
    end else if (!bist && stab_lv) begin
      hold_lim = 64'(cf_hold_time) + 64'(holds) * 64'(cf_hold_rep);
      if (clicks <= 8'd1 && cf_hold_time != 16'd0 && 64'(delta) > hold_lim &&
          (cf_hold_rep != 16'd0 || holds == 8'd0)) begin
        kinds.push_back(EV_HOLD);
        holds = sat_bump(holds);
      end
    end else if (cf_gap == 16'd0) begin
      holds = 8'd0;
      clicks = 8'd0;
    end else if (delta > 32'(cf_gap)) begin
      if (holds == 8'd0) begin
        if (clicks >= 8'd1 && clicks <= CLICK_LIMIT)
          kinds.push_back(EV_CLICK_BASE + 5'(clicks - 8'd1));
        if (clicks >= CLICK_LIMIT) kinds.push_back(EV_CRAZY);
      end else if (clicks >= 8'd1 && clicks <= CLICK_LIMIT + 8'd1) begin
        kinds.push_back(EV_LONG_BASE + 5'(clicks - 8'd1));
      end
      holds = 8'd0;
      clicks = 8'd0;
    end
    foreach (kinds[k]) begin
      ev.kind = kinds[k];
      ev.level = stab_lv;
      ev.last = (k == kinds.size() - 1);
      event_q.push_back(ev);
    end
  endfunction

  // Input side: one tick per transaction, with random gaps between ticks.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_tick(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          next_tick = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_tick.valid;
          in_tdata <= next_tick.code;
          if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 14);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each event transaction and applies backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (event_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event: kind %0d tdata %0h last %0d",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want_ev = event_q.pop_front();
          if (out_tuser !== want_ev.kind || out_tdata !== {7'd0, want_ev.level} ||
              out_tlast !== want_ev.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want kind %0d lvl %0d last %0d, got %0d data %0h last %0d",
                       want_ev.kind, want_ev.level, want_ev.last,
                       out_tuser, out_tdata, out_tlast);
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait = RX_HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic void queue_tick(input logic cv, input logic [31:0] code);
    tick_q.push_back({cv, code});
    queued_ticks++;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_CODE_ON:   cf_code_on = val;
      REG_CODE_OFF:  cf_code_off = val;
      REG_MODE:      cf_mode = val[1:0];
      REG_DEBOUNCE:  cf_debounce = val[15:0];
      REG_NOISE:     cf_noise = val[15:0];
      REG_HOLD_TIME: cf_hold_time = val[15:0];
      REG_HOLD_REP:  cf_hold_rep = val[15:0];
      default:       cf_gap = val[15:0];
    endcase
  endtask

  task automatic set_cfg(input logic [31:0] on_code, input logic [31:0] off_code,
                         input logic [1:0] mode, input logic [15:0] deb,
                         input logic [15:0] noise, input logic [15:0] hold_t,
                         input logic [15:0] hold_r, input logic [15:0] gap);
    reg_write(REG_CODE_ON, on_code);
    reg_write(REG_CODE_OFF, off_code);
    reg_write(REG_MODE, {30'd0, mode});
    reg_write(REG_DEBOUNCE, {16'd0, deb});
    reg_write(REG_NOISE, {16'd0, noise});
    reg_write(REG_HOLD_TIME, {16'd0, hold_t});
    reg_write(REG_HOLD_REP, {16'd0, hold_r});
    reg_write(REG_GAP, {16'd0, gap});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (tick_q.size() != 0 || in_tvalid || event_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed press and release sequences, with some stray codes.
  task automatic add_session(input int n);
    int target;
    target = queued_ticks + n;
    while (queued_ticks < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          queue_tick(1'b1, cf_code_on);
          repeat ($urandom_range(0, 7)) queue_tick(1'b0, $urandom());
          queue_tick(1'b1, cf_code_off);
          repeat ($urandom_range(0, 5)) queue_tick(1'b0, $urandom());
        end
        6: repeat ($urandom_range(3, 12)) queue_tick(1'b0, $urandom());
        7: queue_tick(1'b1, $urandom());
        8: queue_tick(1'b1, $urandom_range(0, 1) ? cf_code_on : cf_code_off);
        default: begin
          queue_tick(1'b1, cf_code_on);
          queue_tick(1'b1, cf_code_on);
        end
      endcase
    end
  endtask

  initial begin
    logic [31:0] code_a;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Plain mode, no delays, counters cleared on every idle tick while released.
    set_cfg(32'hFFFF_FFFF, 32'h0000_0000, MODE_PLAIN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_tick(1'b0, 32'hFFFF_FFFF);
    queue_tick(1'b1, 32'hFFFF_FFFF);
    queue_tick(1'b1, 32'h1234_5678);
    queue_tick(1'b1, 32'h0000_0000);
    queue_tick(1'b1, 32'h0000_0000);
    queue_tick(1'b0, 32'h0000_0000);
    add_session(20);
    wait_idle();

    // Bistable counting: a crazy clicker run, then a six click sequence.
    code_a = $urandom();
    set_cfg(code_a, ~code_a, MODE_BIST, 16'd0, 16'd0, 16'd0, 16'd0, 16'd3);
    for (int i = 0; i < 12; i++) queue_tick(1'b1, i[0] ? cf_code_off : cf_code_on);
    repeat (5) queue_tick(1'b0, $urandom());
    for (int i = 0; i < 6; i++) queue_tick(1'b1, i[0] ? cf_code_off : cf_code_on);
    repeat (5) queue_tick(1'b0, $urandom());
    add_session(20);
    wait_idle();

    // Plain mode with repeated holds: hold then ten more presses gives the top long click.
    set_cfg(32'hA5A5_A5A5, 32'h5A5A_5A5A, MODE_PLAIN, 16'd1, 16'd0, 16'd2, 16'd1, 16'd4);
    queue_tick(1'b1, cf_code_on);
    repeat (5) queue_tick(1'b0, $urandom());
    queue_tick(1'b1, cf_code_off);
    queue_tick(1'b0, $urandom());
    for (int i = 0; i < 10; i++) begin
      queue_tick(1'b1, cf_code_on);
      queue_tick(1'b0, $urandom());
      queue_tick(1'b1, cf_code_off);
      queue_tick(1'b0, $urandom());
    end
    repeat (6) queue_tick(1'b0, $urandom());
    wait_idle();

    // Monostable with a zero on code: the level falls back to pressed.
    set_cfg(32'h0000_0000, $urandom() | 32'd1, MODE_MONO, 16'd3, 16'd2, 16'd4, 16'd0, 16'd5);
    add_session(30);
    wait_idle();

    // Monostable and bistable together, with a long receiver stall.
    set_cfg($urandom() | 32'd1, $urandom(), MODE_MONO | MODE_BIST,
            16'd2, 16'd1, 16'd1, 16'd3, 16'd6);
    rx_hold_req = 1'b1;
    add_session(30);
    wait_idle();

    // Largest delays, and equal on and off codes.
    code_a = $urandom();
    set_cfg(code_a, code_a, MODE_PLAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_session(15);
    wait_idle();

    // Three events per tick against a stalled receiver.
    code_a = $urandom();
    set_cfg(code_a, ~code_a, MODE_BIST, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) queue_tick(1'b1, i[0] ? cf_code_off : cf_code_on);
    wait_idle();

    // Repeated holds on one long press.
    set_cfg(code_a, ~code_a, MODE_PLAIN, 16'd0, 16'd0, 16'd1, 16'd1, 16'd2);
    queue_tick(1'b1, cf_code_off);
    repeat (4) queue_tick(1'b0, $urandom());
    queue_tick(1'b1, cf_code_on);
    repeat (30) queue_tick(1'b0, $urandom());
    queue_tick(1'b1, cf_code_off);
    repeat (4) queue_tick(1'b0, $urandom());
    wait_idle();

    // Random settings, both sides at full rate.
    idle_on = 1'b0;
    set_cfg($urandom(), $urandom(), 2'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
            16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
            16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)));
    add_session(30);
    wait_idle();

    if (mismatches == 0 && event_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/rbed_pkg.sv
rtl/remote_button_event_detector_top.sv
dv/testbench.sv
